// File: hw/rtl/tle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tle_pkg
// Shared types and codes for the terminal line editor: request types,
// control keys, the editor state record and the result record.
// ----------------------------------------------------------------------------
package tle_pkg;

    // request type codes
    localparam logic [1:0] REQ_BEGIN_RD = 2'd0;
    localparam logic [1:0] REQ_BEGIN_WR = 2'd1;
    localparam logic [1:0] REQ_KEY      = 2'd2;
    localparam logic [1:0] REQ_TICK     = 2'd3;

    // control keys
    localparam logic [7:0] KEY_LF    = 8'd10;
    localparam logic [7:0] KEY_CR    = 8'd13;
    localparam logic [7:0] KEY_BS    = 8'd8;
    localparam logic [7:0] KEY_DEL   = 8'd127;
    localparam logic [7:0] KEY_SPACE = 8'd32;

    typedef struct packed {
        logic [7:0]  cursor_pos;
        logic [15:0] bytes_done;
        logic [15:0] request_len;
        logic        busy;
        logic        is_write;
    } t_state;

    typedef struct packed {
        logic        echo_valid;
        logic [7:0]  echo_char;
        logic [7:0]  echo_pos;
        logic [7:0]  cursor_now;
        logic        buf_write;
        logic [15:0] buf_index;
        logic [7:0]  buf_data;
        logic        done_res;
        logic [15:0] final_count;
        logic        rejected;
    } t_result;

endpackage

// File: hw/rtl/tle_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tle_step
// Next-state and result logic for one beat of the line editor: request
// open, key echo and buffering, backspace, newline and output ticks.
// ----------------------------------------------------------------------------
module tle_step #(
    parameter int ROW_WIDTH = 32
) (
    input  tle_pkg::t_state  i_state,
    input  logic [1:0]       i_req_type,
    input  logic [15:0]      i_req_len,
    input  logic [7:0]       i_char_in,
    output tle_pkg::t_state  o_state,
    output tle_pkg::t_result o_result
);
    import tle_pkg::*;

    // start of the next row for every cursor value
    logic [7:0]  w_row_tbl [256];
    logic [15:0] w_bd_inc;
    logic [15:0] w_bd_dec;
    logic [7:0]  w_cur_inc;
    logic [7:0]  w_cur_dec;

    for (genvar g = 0; g < 256; g++) begin : g_row
        assign w_row_tbl[g] = 8'(((g / ROW_WIDTH) + 1) * ROW_WIDTH);
    end

    assign w_bd_inc  = i_state.bytes_done + 16'd1;
    assign w_bd_dec  = i_state.bytes_done - 16'd1;
    assign w_cur_inc = i_state.cursor_pos + 8'd1;
    assign w_cur_dec = i_state.cursor_pos - 8'd1;

    always_comb begin
        t_state  n_st;
        t_result res;
        n_st = i_state;
        res  = '0;
        case (i_req_type)
            REQ_BEGIN_RD, REQ_BEGIN_WR: begin
                if (i_state.busy || i_req_len == 16'd0) begin
                    res.rejected = 1'b1;
                end else begin
                    n_st.busy        = 1'b1;
                    n_st.is_write    = (i_req_type == REQ_BEGIN_WR);
                    n_st.request_len = i_req_len;
                    n_st.bytes_done  = 16'd0;
                end
            end
            REQ_KEY: begin
                if (!i_state.busy || i_state.is_write) begin
                    res.rejected = 1'b1;
                end else if (i_char_in == KEY_CR || i_char_in == KEY_LF) begin
                    n_st.cursor_pos = w_row_tbl[i_state.cursor_pos];
                    res.done_res    = 1'b1;
                    res.final_count = i_state.bytes_done;
                    n_st.busy       = 1'b0;
                end else if (i_char_in == KEY_DEL || i_char_in == KEY_BS) begin
                    if (i_state.bytes_done != 16'd0) begin
                        n_st.bytes_done = w_bd_dec;
                        n_st.cursor_pos = w_cur_dec;
                        res.echo_valid  = 1'b1;
                        res.echo_char   = KEY_SPACE;
                        res.echo_pos    = w_cur_dec;
                        res.buf_write   = 1'b1;
                        res.buf_index   = w_bd_dec;
                    end
                end else begin
                    res.echo_valid  = 1'b1;
                    res.echo_char   = i_char_in;
                    res.echo_pos    = i_state.cursor_pos;
                    n_st.cursor_pos = w_cur_inc;
                    res.buf_write   = 1'b1;
                    res.buf_index   = i_state.bytes_done;
                    res.buf_data    = i_char_in;
                    n_st.bytes_done = w_bd_inc;
                    if (w_bd_inc == i_state.request_len) begin
                        res.done_res    = 1'b1;
                        res.final_count = w_bd_inc;
                        n_st.busy       = 1'b0;
                    end
                end
            end
            default: begin
                if (!i_state.busy || !i_state.is_write) begin
                    res.rejected = 1'b1;
                end else begin
                    res.echo_valid  = 1'b1;
                    res.echo_char   = i_char_in;
                    res.echo_pos    = i_state.cursor_pos;
                    n_st.cursor_pos = w_cur_inc;
                    n_st.bytes_done = w_bd_inc;
                    if (w_bd_inc == i_state.request_len) begin
                        res.done_res    = 1'b1;
                        res.final_count = w_bd_inc;
                        n_st.busy       = 1'b0;
                    end
                end
            end
        endcase
        res.cursor_now = n_st.cursor_pos;
        o_state  = n_st;
        o_result = res;
    end

endmodule

// File: hw/rtl/terminal_line_editor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terminal_line_editor_core
// Line discipline for a character display: read requests echo and buffer
// typed keys with backspace and newline handling, write requests echo
// output bytes; every beat gives one result.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+----------------------------------
//  request  | in        | i_valid / o_stall  | i_req_type, i_req_len, i_char_in
//  result   | out       | o_valid / i_stall  | o_echo_*, o_cursor_now, o_buf_*,
//           |           |                    | o_done_res, o_final_count,
//           |           |                    | o_rejected
//
// one beat per cycle sustained while i_stall is low; a beat passes from accept to result
// through the input register and the result register around the step logic.
// the editor state updates as a beat moves from the input register into
// the result register. synchronous active-low reset clears the state and
// both valid flags. a stalled result holds the pipe; the input register
// then takes a beat only while it is empty.
// ----------------------------------------------------------------------------
module terminal_line_editor_core #(
    parameter int ROW_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_req_len,
    input  logic [7:0]  i_char_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_echo_valid,
    output logic [7:0]  o_echo_char,
    output logic [7:0]  o_echo_pos,
    output logic [7:0]  o_cursor_now,
    output logic        o_buf_write,
    output logic [15:0] o_buf_index,
    output logic [7:0]  o_buf_data,
    output logic        o_done_res,
    output logic [15:0] o_final_count,
    output logic        o_rejected
);
    import tle_pkg::*;

    logic        r_in_vld;
    logic [1:0]  r_req_type;
    logic [15:0] r_req_len;
    logic [7:0]  r_char_in;
    logic        r_out_vld;
    t_result     r_res;
    t_state      r_state;
    t_state      n_state;
    t_result     n_res;
    logic        w_adv;
    logic        w_take;

    // beat leaves the input register when the result register is empty or not stalled
    assign w_adv   = r_in_vld && (!r_out_vld || !i_stall);
    assign o_stall = r_in_vld && !w_adv;
    assign w_take  = i_valid && !o_stall;

    tle_step #(
        .ROW_WIDTH (ROW_WIDTH)
    ) u_step (
        .i_state    (r_state),
        .i_req_type (r_req_type),
        .i_req_len  (r_req_len),
        .i_char_in  (r_char_in),
        .o_state    (n_state),
        .o_result   (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= '0;
        end else begin
            if (w_take) begin
                r_in_vld <= 1'b1;
            end else if (w_adv) begin
                r_in_vld <= 1'b0;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
                r_state   <= n_state;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_req_type <= i_req_type;
            r_req_len  <= i_req_len;
            r_char_in  <= i_char_in;
        end
        if (w_adv) begin
            r_res <= n_res;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_echo_valid  = r_res.echo_valid;
    assign o_echo_char   = r_res.echo_char;
    assign o_echo_pos    = r_res.echo_pos;
    assign o_cursor_now  = r_res.cursor_now;
    assign o_buf_write   = r_res.buf_write;
    assign o_buf_index   = r_res.buf_index;
    assign o_buf_data    = r_res.buf_data;
    assign o_done_res    = r_res.done_res;
    assign o_final_count = r_res.final_count;
    assign o_rejected    = r_res.rejected;

`ifndef SYNTH
    a_rej_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_res.rejected |-> !r_res.echo_valid && !r_res.buf_write
            && !r_res.done_res)
        else $error("rejected beat has side effects");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_state))
        else $error("editor state moved without a beat");

    a_busy_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $fell(r_state.busy) |-> r_out_vld && r_res.done_res)
        else $error("request closed without a done result");

    a_count_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_res.done_res |-> r_res.final_count == 16'd0)
        else $error("final count set on a beat that is not done");

    a_tick_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_res.done_res && r_res.echo_valid |-> r_res.final_count != 16'd0)
        else $error("request finished on an echo with zero count");
`endif

endmodule

// File: sim/terminal_line_editor_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terminal_line_editor_core_test
// Self-checking bench for the line editor core. A short table of directed
// beats is followed by random request sequences that are mostly well formed.
// Each accepted beat is run through a local model of the editor state, and
// each result beat is compared field by field with the oldest queued expectation.
// ----------------------------------------------------------------------------
module terminal_line_editor_core_test;

    import tle_pkg::*;

    localparam int ROW_COLS     = 32;
    localparam int RANDOM_BEATS = 1425;
    localparam int TAIL_BEATS   = 150;
    localparam int LONG_HOLD    = 80;
    localparam int DRAIN_LIMIT  = 2000;

    typedef struct {
        logic [1:0]  kind;
        logic [15:0] len;
        logic [7:0]  ch;
        bit          typed;
        t_result     want;
    } t_row;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_valid    = 1'b0;
    logic [1:0]  i_req_type = '0;
    logic [15:0] i_req_len  = '0;
    logic [7:0]  i_char_in  = '0;
    logic        i_stall    = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic        o_echo_valid;
    logic [7:0]  o_echo_char;
    logic [7:0]  o_echo_pos;
    logic [7:0]  o_cursor_now;
    logic        o_buf_write;
    logic [15:0] o_buf_index;
    logic [7:0]  o_buf_data;
    logic        o_done_res;
    logic [15:0] o_final_count;
    logic        o_rejected;

    t_state  line_state;
    t_result pending_results [$];
    t_row    directed_rows [0:24];
    int      fault_count  = 0;
    int      result_count = 0;
    bit      tail_phase   = 1'b0;
    bit      hold_pending = 1'b0;

    terminal_line_editor_core #(
        .ROW_WIDTH(ROW_COLS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_req_type(i_req_type),
        .i_req_len(i_req_len),
        .i_char_in(i_char_in),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_echo_valid(o_echo_valid),
        .o_echo_char(o_echo_char),
        .o_echo_pos(o_echo_pos),
        .o_cursor_now(o_cursor_now),
        .o_buf_write(o_buf_write),
        .o_buf_index(o_buf_index),
        .o_buf_data(o_buf_data),
        .o_done_res(o_done_res),
        .o_final_count(o_final_count),
        .o_rejected(o_rejected)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic t_result res(input logic ev, input logic [7:0] ec, input logic [7:0] ep,
                                    input logic [7:0] cur, input logic bw,
                                    input logic [15:0] bi, input logic [7:0] bd,
                                    input logic dn, input logic [15:0] fc, input logic rj);
        t_result r;
        r.echo_valid  = ev;
        r.echo_char   = ec;
        r.echo_pos    = ep;
        r.cursor_now  = cur;
        r.buf_write   = bw;
        r.buf_index   = bi;
        r.buf_data    = bd;
        r.done_res    = dn;
        r.final_count = fc;
        r.rejected    = rj;
        return r;
    endfunction

    // advances the editor state by one request beat and returns its result
    function automatic t_result step_line(input logic [1:0] kind, input logic [15:0] len,
                                          input logic [7:0] ch);
        t_result r;
        int      row_end;
        r = '0;
        case (kind)
            REQ_BEGIN_RD, REQ_BEGIN_WR: begin
                if (line_state.busy || len == 16'd0) begin
                    r.rejected = 1'b1;
                end else begin
                    line_state.busy        = 1'b1;
                    line_state.is_write    = (kind == REQ_BEGIN_WR);
                    line_state.request_len = len;
                    line_state.bytes_done  = 16'd0;
                end
            end
            REQ_KEY: begin
                if (!line_state.busy || line_state.is_write) begin
                    r.rejected = 1'b1;
                end else if (ch == KEY_CR || ch == KEY_LF) begin
                    row_end = (int'(line_state.cursor_pos) / ROW_COLS + 1) * ROW_COLS;
                    line_state.cursor_pos = row_end[7:0];
                    r.done_res    = 1'b1;
                    r.final_count = line_state.bytes_done;
                    line_state.busy = 1'b0;
                end else if (ch == KEY_BS || ch == KEY_DEL) begin
                    // rub out the last byte, nothing to do on an empty line
                    if (line_state.bytes_done != 16'd0) begin
                        line_state.bytes_done = line_state.bytes_done - 16'd1;
                        line_state.cursor_pos = line_state.cursor_pos - 8'd1;
                        r.echo_valid = 1'b1;
                        r.echo_char  = KEY_SPACE;
                        r.echo_pos   = line_state.cursor_pos;
                        r.buf_write  = 1'b1;
                        r.buf_index  = line_state.bytes_done;
                    end
                end else begin
                    r.echo_valid = 1'b1;
                    r.echo_char  = ch;
                    r.echo_pos   = line_state.cursor_pos;
                    r.buf_write  = 1'b1;
                    r.buf_index  = line_state.bytes_done;
                    r.buf_data   = ch;
                    line_state.cursor_pos = line_state.cursor_pos + 8'd1;
                    line_state.bytes_done = line_state.bytes_done + 16'd1;
                    if (line_state.bytes_done == line_state.request_len) begin
                        r.done_res      = 1'b1;
                        r.final_count   = line_state.bytes_done;
                        line_state.busy = 1'b0;
                    end
                end
            end
            default: begin
                if (!line_state.busy || !line_state.is_write) begin
                    r.rejected = 1'b1;
                end else begin
                    r.echo_valid = 1'b1;
                    r.echo_char  = ch;
                    r.echo_pos   = line_state.cursor_pos;
                    line_state.cursor_pos = line_state.cursor_pos + 8'd1;
                    line_state.bytes_done = line_state.bytes_done + 16'd1;
                    if (line_state.bytes_done == line_state.request_len) begin
                        r.done_res      = 1'b1;
                        r.final_count   = line_state.bytes_done;
                        line_state.busy = 1'b0;
                    end
                end
            end
        endcase
        r.cursor_now = line_state.cursor_pos;
        return r;
    endfunction

    task automatic note_fault(input string what);
        fault_count++;
        if (fault_count <= 10) begin
            $display("%0t: %s", $time, what);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            note_fault($sformatf("result %0d %s: expected %0h, got %0h",
                                 result_count, name, want, got));
        end
    endtask

    // offers one beat, holds it until taken, queues the expected result, then maybe idles
    task automatic deliver_beat(input logic [1:0] kind, input logic [15:0] len,
                                input logic [7:0] ch, input bit typed, input t_result want);
        t_result predicted;
        i_valid    <= 1'b1;
        i_req_type <= kind;
        i_req_len  <= len;
        i_char_in  <= ch;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predicted = step_line(kind, len, ch);
        pending_results.push_back(typed ? want : predicted);
        if (!tail_phase && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                note_fault($sformatf("result %0d arrived with nothing expected", result_count));
            end else begin
                want = pending_results.pop_front();
                check_field("echo_valid", 16'(want.echo_valid), 16'(o_echo_valid));
                check_field("echo_char", 16'(want.echo_char), 16'(o_echo_char));
                check_field("echo_pos", 16'(want.echo_pos), 16'(o_echo_pos));
                check_field("cursor_now", 16'(want.cursor_now), 16'(o_cursor_now));
                check_field("buf_write", 16'(want.buf_write), 16'(o_buf_write));
                check_field("buf_index", want.buf_index, o_buf_index);
                check_field("buf_data", 16'(want.buf_data), 16'(o_buf_data));
                check_field("done_res", 16'(want.done_res), 16'(o_done_res));
                check_field("final_count", want.final_count, o_final_count);
                check_field("rejected", 16'(want.rejected), 16'(o_rejected));
            end
            result_count++;
        end
    end

    // result side back-pressure
    initial begin : result_sink
        int span;
        bit hold;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (tail_phase) begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else if (hold_pending) begin
                hold_pending = 1'b0;
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                hold = ($urandom_range(0, 3) == 0);
                span = hold ? $urandom_range(1, 13) : $urandom_range(1, 40);
                i_stall <= hold;
                repeat (span) @(posedge i_clk);
            end
        end
    end

    initial begin : request_source
        logic [1:0]  kind;
        logic [15:0] len;
        logic [7:0]  ch;
        int          pick;
        int          drain;

        line_state = '0;
        directed_rows = '{
            //  type          length    char        typed  expected
            '{REQ_KEY,      16'd0,    8'h41,     1'b1, res(0, 0, 0, 0, 0, 0, 0, 0, 0, 1)},
            '{REQ_TICK,     16'hFFFF, 8'hFF,     1'b1, res(0, 0, 0, 0, 0, 0, 0, 0, 0, 1)},
            '{REQ_BEGIN_RD, 16'd0,    8'h00,     1'b1, res(0, 0, 0, 0, 0, 0, 0, 0, 0, 1)},
            '{REQ_BEGIN_WR, 16'd0,    8'h00,     1'b1, res(0, 0, 0, 0, 0, 0, 0, 0, 0, 1)},
            '{REQ_BEGIN_RD, 16'd3,    8'hFF,     1'b1, res(0, 0, 0, 0, 0, 0, 0, 0, 0, 0)},
            '{REQ_BEGIN_WR, 16'd5,    8'h00,     1'b1, res(0, 0, 0, 0, 0, 0, 0, 0, 0, 1)},
            '{REQ_TICK,     16'd0,    8'h55,     1'b1, res(0, 0, 0, 0, 0, 0, 0, 0, 0, 1)},
            '{REQ_KEY,      16'd0,    KEY_BS,    1'b1, res(0, 0, 0, 0, 0, 0, 0, 0, 0, 0)},
            '{REQ_KEY,      16'd0,    8'hFF,     1'b1, res(1, 8'hFF, 0, 1, 1, 0, 8'hFF, 0, 0, 0)},
            '{REQ_KEY,      16'd0,    KEY_DEL,   1'b0, '0},
            '{REQ_KEY,      16'd0,    8'h00,     1'b0, '0},
            '{REQ_KEY,      16'd0,    8'h7E,     1'b0, '0},
            '{REQ_KEY,      16'd0,    8'h80,     1'b0, '0},
            '{REQ_BEGIN_RD, 16'hFFFF, 8'h00,     1'b0, '0},
            '{REQ_KEY,      16'd0,    8'h78,     1'b0, '0},
            '{REQ_KEY,      16'd0,    KEY_CR,    1'b0, '0},
            '{REQ_BEGIN_WR, 16'd2,    8'h00,     1'b0, '0},
            '{REQ_KEY,      16'd0,    8'h61,     1'b0, '0},
            '{REQ_TICK,     16'd0,    8'h00,     1'b0, '0},
            '{REQ_TICK,     16'd0,    8'hFF,     1'b0, '0},
            '{REQ_BEGIN_RD, 16'd4,    8'h00,     1'b0, '0},
            '{REQ_KEY,      16'd0,    KEY_LF,    1'b0, '0},
            '{REQ_BEGIN_WR, 16'd1,    8'h00,     1'b0, '0},
            '{REQ_TICK,     16'd0,    8'h5A,     1'b0, '0},
            '{REQ_KEY,      16'd0,    KEY_BS,    1'b0, '0}
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            deliver_beat(directed_rows[r].kind, directed_rows[r].len, directed_rows[r].ch,
                         directed_rows[r].typed, directed_rows[r].want);
        end

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n == RANDOM_BEATS - TAIL_BEATS) tail_phase = 1'b1;
            if (n == 300) hold_pending = 1'b1;
            if (n == 700) begin
                // let the pipe run dry before carrying on
                i_valid <= 1'b0;
                do @(posedge i_clk); while (pending_results.size() != 0);
            end

            pick = $urandom_range(0, 99);
            ch   = 8'($urandom_range(0, 255));
            len  = 16'($urandom_range(1, 12));
            if (pick < 8) begin
                kind = 2'($urandom_range(0, 3));
                len  = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(0, 65535));
                // a stray write opened with a huge length would never finish
                if (!line_state.busy && kind == REQ_BEGIN_WR) len = 16'($urandom_range(0, 8));
            end else if (!line_state.busy) begin
                kind = ($urandom_range(0, 9) < 7) ? REQ_BEGIN_RD : REQ_BEGIN_WR;
                if (kind == REQ_BEGIN_RD && $urandom_range(0, 4) == 0) begin
                    len = 16'($urandom_range(1, 65535));
                end else if (kind == REQ_BEGIN_WR && $urandom_range(0, 9) == 0) begin
                    len = 16'($urandom_range(13, 300));
                end
            end else if (line_state.is_write) begin
                kind = REQ_TICK;
            end else begin
                kind = REQ_KEY;
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    ch = pick[0] ? KEY_BS : KEY_DEL;
                end else if (pick < 16) begin
                    ch = pick[0] ? KEY_CR : KEY_LF;
                end
            end
            deliver_beat(kind, len, ch, 1'b0, '0);
        end

        i_valid <= 1'b0;
        drain = 0;
        while (pending_results.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (6) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            note_fault($sformatf("%0d results never arrived", pending_results.size()));
        end

        if (fault_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/tle_pkg.sv
hw/rtl/tle_step.sv
hw/rtl/terminal_line_editor_core.sv
sim/terminal_line_editor_core_test.sv
